>>> hdl/assert_macros.svh
// Assertion macros for the 3x3 inverse block.
// Expects signals clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent on the same edge
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// expression must never hold
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

>>> hdl/mat3i_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// No dependencies; used by every mat3i_* module and the top level.
package mat3i_pkg;

  localparam int NEL       = 9;    // elements per matrix
  localparam int EW        = 32;   // element width
  localparam int PW        = 64;   // product / cofactor width
  localparam int QW        = 34;   // quotient bits kept (bits 33..0)
  localparam int DETW      = 98;   // signed determinant width
  localparam int DW        = 97;   // determinant magnitude width
  localparam int CW        = 131;  // divider datapath width
  localparam int OVF_SHIFT = 34;   // quotient >= 2^34 flags overflow early
  localparam int NSTEP     = 34;   // one divider step per quotient bit

  localparam logic [EW-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] NEG_MIN = 32'h8000_0000;

  typedef logic [NEL-1:0][EW-1:0] mat_t;
  typedef logic [NEL-1:0][PW-1:0] adj_t;
  typedef logic [NEL-1:0][CW-1:0] rem_t;
  typedef logic [NEL-1:0][QW-1:0] quo_t;
  typedef logic [DW-1:0]          den_t;
  typedef logic [3:0]             idx_t;

  // sideband that rides along with the divider
  typedef struct packed {
    logic           singular;
    logic [NEL-1:0] neg;
    logic [NEL-1:0] ovf;
    mat_t           elems;
  } side_t;

  // adj[i] = e[PA]*e[PB] - e[MA]*e[MB]
  localparam idx_t PA [NEL] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam idx_t PB [NEL] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam idx_t MA [NEL] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam idx_t MB [NEL] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

endpackage

>>> hdl/mat3i_adj.sv
// Adjugate stages: 18 signed 32x32 products, then pairwise differences.
// Depends on mat3i_pkg.
module mat3i_adj (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  mat3i_pkg::mat_t   in_elems,
  output logic              out_vld,
  output mat3i_pkg::adj_t   out_adj,
  output mat3i_pkg::mat_t   out_elems
);

  logic signed [mat3i_pkg::PW-1:0] pa_nxt [mat3i_pkg::NEL];
  logic signed [mat3i_pkg::PW-1:0] pb_nxt [mat3i_pkg::NEL];
  logic signed [mat3i_pkg::PW-1:0] pa_r   [mat3i_pkg::NEL];
  logic signed [mat3i_pkg::PW-1:0] pb_r   [mat3i_pkg::NEL];
  mat3i_pkg::adj_t adj_nxt, adj_r;
  mat3i_pkg::mat_t e1_r, e2_r;
  logic            v1_r, v2_r;

  always_comb begin
    for (int i = 0; i < mat3i_pkg::NEL; i++) begin
      pa_nxt[i] = $signed(in_elems[mat3i_pkg::PA[i]]) * $signed(in_elems[mat3i_pkg::PB[i]]);
      pb_nxt[i] = $signed(in_elems[mat3i_pkg::MA[i]]) * $signed(in_elems[mat3i_pkg::MB[i]]);
    end
  end

  // 64-bit wrap on the difference is intended
  always_comb begin
    for (int i = 0; i < mat3i_pkg::NEL; i++) begin
      adj_nxt[i] = pa_r[i] - pb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    pb_r  <= pb_nxt;
    e1_r  <= in_elems;
    adj_r <= adj_nxt;
    e2_r  <= e1_r;
  end

  assign out_vld   = v2_r;
  assign out_adj   = adj_r;
  assign out_elems = e2_r;

endmodule

>>> hdl/mat3i_det.sv
// Determinant stages: split 64x32 partial products, terms, sum,
// magnitude and numerator setup, early overflow test. Depends on mat3i_pkg.
module mat3i_det #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  mat3i_pkg::adj_t   in_adj,
  input  mat3i_pkg::mat_t   in_elems,
  output logic              out_vld,
  output mat3i_pkg::side_t  out_side,
  output mat3i_pkg::den_t   out_den,
  output mat3i_pkg::rem_t   out_rem
);

  localparam int NUM_SHIFT = 2 * FRAC_BITS;

  // T1: partial products
  logic signed [64:0] lo_nxt [3];
  logic signed [63:0] hi_nxt [3];
  logic signed [64:0] lo_r   [3];
  logic signed [63:0] hi_r   [3];
  // T2: terms
  logic signed [95:0] term_nxt [3];
  logic signed [95:0] term_r   [3];
  // T3: sum
  logic signed [mat3i_pkg::DETW-1:0] det_nxt, det_r;
  // T4: magnitudes
  logic [mat3i_pkg::DETW-1:0] dabs;
  mat3i_pkg::den_t            dmag_nxt, dmag_r, dmag5_r;
  logic [mat3i_pkg::PW-1:0]   amag;
  mat3i_pkg::rem_t            num_nxt, num_r, num5_r;
  logic [mat3i_pkg::NEL-1:0]  neg_nxt, neg_r;
  logic                       sing_r;
  // T5: overflow test
  logic [mat3i_pkg::CW-1:0]   dlim;
  mat3i_pkg::side_t           side_nxt, side_r;

  mat3i_pkg::adj_t adj1_r, adj2_r, adj3_r;
  mat3i_pkg::mat_t e1_r, e2_r, e3_r, e4_r;
  logic            v1_r, v2_r, v3_r, v4_r, v5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_nxt[k] = $signed({1'b0, in_adj[3*k][31:0]}) * $signed(in_elems[k]);
      hi_nxt[k] = $signed(in_adj[3*k][63:32]) * $signed(in_elems[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_nxt[k] = $signed({hi_r[k], 32'd0}) + lo_r[k];
    end
  end

  assign det_nxt = term_r[0] + term_r[1] + term_r[2];

  always_comb begin
    dabs     = det_r[mat3i_pkg::DETW-1] ? (-det_r) : det_r;
    dmag_nxt = dabs[mat3i_pkg::DW-1:0];
    amag     = '0;
    for (int i = 0; i < mat3i_pkg::NEL; i++) begin
      neg_nxt[i] = adj3_r[i][mat3i_pkg::PW-1] ^ det_r[mat3i_pkg::DETW-1];
      amag       = adj3_r[i][mat3i_pkg::PW-1] ? (-adj3_r[i]) : adj3_r[i];
      num_nxt[i] = {{(mat3i_pkg::CW-mat3i_pkg::PW){1'b0}}, amag} << NUM_SHIFT;
    end
  end

  always_comb begin
    dlim              = {{(mat3i_pkg::CW-mat3i_pkg::DW){1'b0}}, dmag_r} << mat3i_pkg::OVF_SHIFT;
    side_nxt.singular = sing_r;
    side_nxt.neg      = neg_r;
    side_nxt.elems    = e4_r;
    for (int i = 0; i < mat3i_pkg::NEL; i++) begin
      side_nxt.ovf[i] = num_r[i] >= dlim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    adj1_r  <= in_adj;
    e1_r    <= in_elems;
    term_r  <= term_nxt;
    adj2_r  <= adj1_r;
    e2_r    <= e1_r;
    det_r   <= det_nxt;
    adj3_r  <= adj2_r;
    e3_r    <= e2_r;
    dmag_r  <= dmag_nxt;
    num_r   <= num_nxt;
    neg_r   <= neg_nxt;
    sing_r  <= (det_r == '0);
    e4_r    <= e3_r;
    side_r  <= side_nxt;
    dmag5_r <= dmag_r;
    num5_r  <= num_r;
  end

  assign out_vld  = v5_r;
  assign out_side = side_r;
  assign out_den  = dmag5_r;
  assign out_rem  = num5_r;

endmodule

>>> hdl/mat3i_div_step.sv
// One restoring-division step for all nine elements: quotient bit BIT.
// Depends on mat3i_pkg.
module mat3i_div_step #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  mat3i_pkg::side_t  in_side,
  input  mat3i_pkg::den_t   in_den,
  input  mat3i_pkg::rem_t   in_rem,
  input  mat3i_pkg::quo_t   in_quo,
  output logic              out_vld,
  output mat3i_pkg::side_t  out_side,
  output mat3i_pkg::den_t   out_den,
  output mat3i_pkg::rem_t   out_rem,
  output mat3i_pkg::quo_t   out_quo
);

  logic [mat3i_pkg::CW-1:0] dsh;
  logic                     ge;
  mat3i_pkg::rem_t          rem_nxt, rem_r;
  mat3i_pkg::quo_t          quo_nxt, quo_r;
  mat3i_pkg::side_t         side_r;
  mat3i_pkg::den_t          den_r;
  logic                     vld_r;

  always_comb begin
    dsh     = {{(mat3i_pkg::CW-mat3i_pkg::DW){1'b0}}, in_den} << BIT;
    quo_nxt = in_quo;
    ge      = 1'b0;
    for (int i = 0; i < mat3i_pkg::NEL; i++) begin
      ge             = in_rem[i] >= dsh;
      rem_nxt[i]     = ge ? (in_rem[i] - dsh) : in_rem[i];
      quo_nxt[i][BIT] = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    side_r <= in_side;
    den_r  <= in_den;
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_den  = den_r;
  assign out_rem  = rem_r;
  assign out_quo  = quo_r;

endmodule

>>> hdl/matrix3_inverse_unit.sv
// 3x3 fixed-point matrix inverse (adjugate / determinant), fully pipelined.
// An accepted matrix passes the adjugate stages, the determinant stages, 34
// divider steps and the output register. Throughput: one matrix per cycle
// while not busy (reset and the cycle after); the result channel never stalls.
// Reset (rst_n low, synchronous) clears all valid bits; in-flight beats drop.
// Depends on mat3i_pkg, mat3i_adj, mat3i_det, mat3i_div_step, assert_macros.svh.
`include "assert_macros.svh"

module matrix3_inverse_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_elem_0,
  input  logic [31:0] in_elem_1,
  input  logic [31:0] in_elem_2,
  input  logic [31:0] in_elem_3,
  input  logic [31:0] in_elem_4,
  input  logic [31:0] in_elem_5,
  input  logic [31:0] in_elem_6,
  input  logic [31:0] in_elem_7,
  input  logic [31:0] in_elem_8,
  output logic        out_valid,
  output logic [31:0] out_elem_0,
  output logic [31:0] out_elem_1,
  output logic [31:0] out_elem_2,
  output logic [31:0] out_elem_3,
  output logic [31:0] out_elem_4,
  output logic [31:0] out_elem_5,
  output logic [31:0] out_elem_6,
  output logic [31:0] out_elem_7,
  output logic [31:0] out_elem_8,
  output logic        out_singular,
  output logic        out_saturated
);

  localparam int NS = mat3i_pkg::NSTEP;

  logic            busy_r;
  logic            acc;
  mat3i_pkg::mat_t in_mat;

  // adjugate -> determinant
  logic            adj_vld;
  mat3i_pkg::adj_t adj;
  mat3i_pkg::mat_t adj_elems;

  // divider chain, index 0 is the determinant stage output
  logic             vld_s  [NS+1];
  mat3i_pkg::side_t side_s [NS+1];
  mat3i_pkg::den_t  den_s  [NS+1];
  mat3i_pkg::rem_t  rem_s  [NS+1];
  mat3i_pkg::quo_t  quo_s  [NS+1];

  // output stage
  mat3i_pkg::mat_t res_nxt, res_r;
  logic            sat_nxt, sat_r, sing_r, vld_r;
  logic [mat3i_pkg::EW-1:0] qlo;
  logic            sat_seen;

  // busy covers reset and only the first cycle out of it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign acc  = start && !busy_r;

  assign in_mat = {in_elem_8, in_elem_7, in_elem_6, in_elem_5, in_elem_4,
                   in_elem_3, in_elem_2, in_elem_1, in_elem_0};

  mat3i_adj u_adj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (acc),
    .in_elems  (in_mat),
    .out_vld   (adj_vld),
    .out_adj   (adj),
    .out_elems (adj_elems)
  );

  mat3i_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (adj_vld),
    .in_adj   (adj),
    .in_elems (adj_elems),
    .out_vld  (vld_s[0]),
    .out_side (side_s[0]),
    .out_den  (den_s[0]),
    .out_rem  (rem_s[0])
  );

  assign quo_s[0] = '0;

  // one step per quotient bit, MSB (bit 33) first
  for (genvar j = 0; j < NS; j++) begin : g_step
    mat3i_div_step #(
      .BIT (NS - 1 - j)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld_s[j]),
      .in_side  (side_s[j]),
      .in_den   (den_s[j]),
      .in_rem   (rem_s[j]),
      .in_quo   (quo_s[j]),
      .out_vld  (vld_s[j+1]),
      .out_side (side_s[j+1]),
      .out_den  (den_s[j+1]),
      .out_rem  (rem_s[j+1]),
      .out_quo  (quo_s[j+1])
    );
  end

  // sign, clamp, singular echo
  always_comb begin
    sat_nxt = 1'b0;
    qlo     = '0;
    for (int i = 0; i < mat3i_pkg::NEL; i++) begin
      qlo = quo_s[NS][i][mat3i_pkg::EW-1:0];
      if (side_s[NS].singular) begin
        res_nxt[i] = side_s[NS].elems[i];
      end else if (side_s[NS].neg[i]) begin
        if (side_s[NS].ovf[i] || (quo_s[NS][i] > mat3i_pkg::QW'(mat3i_pkg::NEG_MIN))) begin
          res_nxt[i] = mat3i_pkg::NEG_MIN;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[i] = -qlo;
        end
      end else begin
        if (side_s[NS].ovf[i] || (quo_s[NS][i] > mat3i_pkg::QW'(mat3i_pkg::POS_MAX))) begin
          res_nxt[i] = mat3i_pkg::POS_MAX;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[i] = qlo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_s[NS];
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    sat_r  <= sat_nxt;
    sing_r <= side_s[NS].singular;
  end

  assign out_valid     = vld_r;
  assign out_elem_0    = res_r[0];
  assign out_elem_1    = res_r[1];
  assign out_elem_2    = res_r[2];
  assign out_elem_3    = res_r[3];
  assign out_elem_4    = res_r[4];
  assign out_elem_5    = res_r[5];
  assign out_elem_6    = res_r[6];
  assign out_elem_7    = res_r[7];
  assign out_elem_8    = res_r[8];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;

  // some element sits at a rail
  always_comb begin
    sat_seen = 1'b0;
    for (int i = 0; i < mat3i_pkg::NEL; i++) begin
      if (res_r[i] == mat3i_pkg::POS_MAX || res_r[i] == mat3i_pkg::NEG_MIN) begin
        sat_seen = 1'b1;
      end
    end
  end

  // a singular beat never reports saturation
  `ASSERT_NEVER(a_sing_no_sat, out_valid && out_singular && out_saturated)
  // every result traces back to an earlier accept (start while not busy)
  `ASSERT_IMPL(a_latency, out_valid, $past(start && !busy, 42))
  // saturated beats carry at least one clamped element
  `ASSERT_IMPL(a_sat_rail, out_valid && out_saturated, sat_seen)

endmodule
